/* src/contiguous_block_allocator_macros.svh */
// assertion macros for the contiguous block allocator checker
// expects clk_i and rst_ni in the scope of each use
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define CBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cba_pkg.sv */
// shared constants, codes and types of the contiguous block allocator
// no dependencies
`default_nettype none

package cba_pkg;

  localparam int unsigned NUM_BLOCKS = 256;

  localparam int unsigned AW   = $clog2(NUM_BLOCKS);
  localparam int unsigned CW   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned PW   = $clog2(2 * NUM_BLOCKS);
  localparam int unsigned NW   = 9;
  localparam int unsigned SW   = ((PW > NW) ? PW : NW) + 1;
  localparam int unsigned TW   = (CW > NW) ? CW : NW;
  localparam int unsigned OFFW = 28;
  localparam int unsigned IDXW = 8;
  localparam int unsigned SHW  = 5;
  localparam int unsigned STW  = 2;

  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 9;

  localparam logic [SHW-1:0] MAX_SHIFT = 5'd20;
  localparam logic [NW-1:0]  TOTAL_BLOCKS_RESET = 9'd256;
  localparam logic [SHW-1:0] BLOCK_SIZE_LOG2_RESET = 5'd12;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_TOTAL_BLOCKS    = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_BLOCK_SIZE_LOG2 = 1'b1;

  typedef enum logic [STW-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ZERO    = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef struct packed {
    logic          done;
    logic          fail;
    logic [PW-1:0] pos;
    logic [PW-1:0] cand;
    logic [NW-1:0] avail;
    logic          wrapped;
  } step_t;

endpackage

`default_nettype wire

/* src/cba_if.sv */
// request and response channel interfaces of the allocator
// depends on cba_pkg
`default_nettype none

interface cba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [cba_pkg::NW-1:0]     num_blocks;
  logic [cba_pkg::OFFW-1:0]   free_offset;

  modport source (output valid, req_type, num_blocks, free_offset, input ready);
  modport sink (input valid, req_type, num_blocks, free_offset, output ready);
  modport monitor (input valid, ready, req_type, num_blocks, free_offset);
endinterface

interface cba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cba_pkg::STW-1:0]    status;
  logic [cba_pkg::IDXW-1:0]   block_index;
  logic [cba_pkg::OFFW-1:0]   byte_offset;

  modport source (output valid, status, block_index, byte_offset, input ready);
  modport sink (input valid, status, block_index, byte_offset, output ready);
  modport monitor (input valid, ready, status, block_index, byte_offset);
endinterface

`default_nettype wire

/* src/cba_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cba_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/cba_scan_unit.sv */
// one step of the next-fit scan: start check, skip of a run or count of a free block
// depends on cba_pkg
`default_nettype none

module cba_scan_unit (
  input  wire logic                   start_i,
  input  wire logic [cba_pkg::NW-1:0] n_i,
  input  wire logic [cba_pkg::CW-1:0] pool_i,
  input  wire logic [cba_pkg::CW-1:0] cursor_i,
  input  wire logic [cba_pkg::PW-1:0] pos_i,
  input  wire logic [cba_pkg::PW-1:0] cand_i,
  input  wire logic [cba_pkg::NW-1:0] avail_i,
  input  wire logic                   wrapped_i,
  input  wire logic [cba_pkg::NW-1:0] rdata_i,
  output      cba_pkg::step_t         step_o
);

  logic                   skip;
  logic [cba_pkg::SW-1:0] base;
  logic [cba_pkg::SW-1:0] addend;
  logic [cba_pkg::SW-1:0] sum;
  logic [cba_pkg::SW-1:0] chk;
  logic [cba_pkg::SW-1:0] n_ext;
  logic [cba_pkg::SW-1:0] pool_ext;
  logic [cba_pkg::SW-1:0] cursor_ext;
  logic [cba_pkg::NW-1:0] avail_inc;

  assign skip       = (rdata_i != '0);
  assign n_ext      = cba_pkg::SW'(n_i);
  assign pool_ext   = cba_pkg::SW'(pool_i);
  assign cursor_ext = cba_pkg::SW'(cursor_i);
  assign avail_inc  = avail_i + cba_pkg::NW'(1);

  // shared adder: cursor + n at start, pos + run length on a skip, pos + 1 otherwise
  always_comb begin
    if (start_i) begin
      base   = cursor_ext;
      addend = n_ext;
    end else if (skip) begin
      base   = cba_pkg::SW'(pos_i);
      addend = cba_pkg::SW'(rdata_i);
    end else begin
      base   = cba_pkg::SW'(pos_i);
      addend = cba_pkg::SW'(1);
    end
  end

  assign sum = base + addend;
  assign chk = sum + n_ext;

  always_comb begin
    step_o         = '0;
    step_o.pos     = pos_i;
    step_o.cand    = cand_i;
    step_o.avail   = avail_i;
    step_o.wrapped = wrapped_i;
    if (start_i) begin
      step_o.avail = '0;
      if (sum > pool_ext) begin
        step_o.pos     = '0;
        step_o.cand    = '0;
        step_o.wrapped = 1'b1;
        step_o.fail    = (n_ext > pool_ext);
      end else begin
        step_o.pos     = cba_pkg::PW'(cursor_i);
        step_o.cand    = cba_pkg::PW'(cursor_i);
        step_o.wrapped = 1'b0;
      end
    end else if (skip) begin
      step_o.pos   = sum[cba_pkg::PW-1:0];
      step_o.cand  = sum[cba_pkg::PW-1:0];
      step_o.avail = '0;
      if (chk > pool_ext) begin
        if (wrapped_i || (n_ext > cursor_ext)) begin
          step_o.fail = 1'b1;
        end else begin
          step_o.pos     = '0;
          step_o.cand    = '0;
          step_o.wrapped = 1'b1;
        end
      end
    end else begin
      step_o.pos   = sum[cba_pkg::PW-1:0];
      step_o.avail = avail_inc;
      step_o.done  = (avail_inc == n_i);
    end
  end

endmodule

`default_nettype wire

/* src/contiguous_block_allocator.sv */
// top level of the next-fit contiguous block allocator: sequencer, config and result registers
// depends on cba_pkg, cba_if, cba_ram and cba_scan_unit
//
//   channel  dir  handshake      payload
//   in_if    in   valid/ready    req_type, num_blocks, free_offset
//   out_if   out  valid/ready    status, block_index, byte_offset
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// a free, or an allocate rejected at start, goes from accept through S_START and S_RESP to the result
// an allocate goes through S_START, then S_SCAN (a free block counted or a run skipped per step), then S_RESP
// the scan reads one run table entry a cycle through the single ram read port
// after reset the clearing sweep writes every run table entry while in_if.ready stays low
// a result waits in the output register; a finished scan holds until that register is free
`default_nettype none

module contiguous_block_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cba_pkg::CFG_IW-1:0] cfg_idx_i,
  input  wire logic [cba_pkg::CFG_DW-1:0] cfg_data_i,
  cba_req_if.sink                         in_if,
  cba_rsp_if.source                       out_if
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_SCAN,
    S_RESP
  } state_e;

  state_e                     state_q;
  logic [cba_pkg::AW-1:0]     clr_q;
  logic                       req_type_q;
  logic [cba_pkg::NW-1:0]     n_q;
  logic [cba_pkg::OFFW-1:0]   offs_q;
  logic [cba_pkg::CW-1:0]     cursor_q;
  logic [cba_pkg::PW-1:0]     pos_q;
  logic [cba_pkg::PW-1:0]     cand_q;
  logic [cba_pkg::NW-1:0]     avail_q;
  logic                       wrapped_q;
  cba_pkg::status_e           res_status_q;
  logic [cba_pkg::AW-1:0]     res_idx_q;
  logic                       out_valid_q;
  cba_pkg::status_e           out_status_q;
  logic [cba_pkg::IDXW-1:0]   out_idx_q;
  logic [cba_pkg::OFFW-1:0]   out_off_q;
  logic [cba_pkg::NW-1:0]     total_blocks_q;
  logic [cba_pkg::SHW-1:0]    block_size_log2_q;

  logic [cba_pkg::TW-1:0]     tb_ext;
  logic [cba_pkg::CW-1:0]     pool;
  logic [cba_pkg::SHW-1:0]    shamt;
  logic [cba_pkg::OFFW-1:0]   free_idx;
  logic                       free_ok;
  logic [cba_pkg::OFFW-1:0]   res_idx_ext;
  cba_pkg::step_t             step;
  logic                       ram_we;
  logic [cba_pkg::AW-1:0]     ram_waddr;
  logic [cba_pkg::NW-1:0]     ram_wdata;
  logic [cba_pkg::NW-1:0]     ram_rdata;

  assign tb_ext = cba_pkg::TW'(total_blocks_q);

  always_comb begin
    if (total_blocks_q == '0) begin
      pool = cba_pkg::CW'(1);
    end else if (tb_ext > cba_pkg::TW'(cba_pkg::NUM_BLOCKS)) begin
      pool = cba_pkg::CW'(cba_pkg::NUM_BLOCKS);
    end else begin
      pool = cba_pkg::CW'(tb_ext);
    end
  end

  assign shamt       = (block_size_log2_q > cba_pkg::MAX_SHIFT) ? cba_pkg::MAX_SHIFT
                                                                : block_size_log2_q;
  assign free_idx    = offs_q >> shamt;
  assign free_ok     = (free_idx < cba_pkg::OFFW'(pool));
  assign res_idx_ext = cba_pkg::OFFW'(res_idx_q);

  // table writes: clearing sweep, free of an entry, record of a granted run
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_START: begin
        if ((req_type_q == cba_pkg::REQ_FREE) && free_ok) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx[cba_pkg::AW-1:0];
        end
      end
      S_SCAN: begin
        if (step.done) begin
          ram_we    = 1'b1;
          ram_waddr = cand_q[cba_pkg::AW-1:0];
          ram_wdata = n_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cba_ram #(
    .WIDTH (cba_pkg::NW),
    .DEPTH (cba_pkg::NUM_BLOCKS)
  ) u_run_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (step.pos[cba_pkg::AW-1:0]),
    .rdata_o (ram_rdata)
  );

  cba_scan_unit u_scan (
    .start_i   (state_q == S_START),
    .n_i       (n_q),
    .pool_i    (pool),
    .cursor_i  (cursor_q),
    .pos_i     (pos_q),
    .cand_i    (cand_q),
    .avail_i   (avail_q),
    .wrapped_i (wrapped_q),
    .rdata_i   (ram_rdata),
    .step_o    (step)
  );

  assign in_if.ready        = (state_q == S_IDLE);
  assign out_if.valid       = out_valid_q;
  assign out_if.status      = out_status_q;
  assign out_if.block_index = out_idx_q;
  assign out_if.byte_offset = out_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLEAR;
      clr_q             <= '0;
      req_type_q        <= cba_pkg::REQ_ALLOC;
      n_q               <= '0;
      offs_q            <= '0;
      cursor_q          <= '0;
      pos_q             <= '0;
      cand_q            <= '0;
      avail_q           <= '0;
      wrapped_q         <= 1'b0;
      res_status_q      <= cba_pkg::ST_OK;
      res_idx_q         <= '0;
      out_valid_q       <= 1'b0;
      out_status_q      <= cba_pkg::ST_OK;
      out_idx_q         <= '0;
      out_off_q         <= '0;
      total_blocks_q    <= cba_pkg::TOTAL_BLOCKS_RESET;
      block_size_log2_q <= cba_pkg::BLOCK_SIZE_LOG2_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cba_pkg::CFG_TOTAL_BLOCKS:    total_blocks_q    <= cfg_data_i;
          cba_pkg::CFG_BLOCK_SIZE_LOG2: block_size_log2_q <= cfg_data_i[cba_pkg::SHW-1:0];
          default: begin
            total_blocks_q <= total_blocks_q;
          end
        endcase
      end

      if (out_valid_q && out_if.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + cba_pkg::AW'(1);
          if (clr_q == cba_pkg::AW'(cba_pkg::NUM_BLOCKS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_if.valid) begin
            req_type_q <= in_if.req_type;
            n_q        <= in_if.num_blocks;
            offs_q     <= in_if.free_offset;
            state_q    <= S_START;
          end
        end
        S_START: begin
          if (req_type_q == cba_pkg::REQ_FREE) begin
            if (free_ok) begin
              res_status_q <= cba_pkg::ST_OK;
              res_idx_q    <= free_idx[cba_pkg::AW-1:0];
            end else begin
              res_status_q <= cba_pkg::ST_RANGE;
              res_idx_q    <= '0;
            end
            state_q <= S_RESP;
          end else if (n_q == '0) begin
            res_status_q <= cba_pkg::ST_ZERO;
            res_idx_q    <= '0;
            state_q      <= S_RESP;
          end else if (step.fail) begin
            res_status_q <= cba_pkg::ST_NOSPACE;
            res_idx_q    <= '0;
            state_q      <= S_RESP;
          end else begin
            pos_q     <= step.pos;
            cand_q    <= step.cand;
            avail_q   <= step.avail;
            wrapped_q <= step.wrapped;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step.fail) begin
            res_status_q <= cba_pkg::ST_NOSPACE;
            res_idx_q    <= '0;
            state_q      <= S_RESP;
          end else if (step.done) begin
            res_status_q <= cba_pkg::ST_OK;
            res_idx_q    <= cand_q[cba_pkg::AW-1:0];
            cursor_q     <= step.pos[cba_pkg::CW-1:0];
            state_q      <= S_RESP;
          end else begin
            pos_q     <= step.pos;
            cand_q    <= step.cand;
            avail_q   <= step.avail;
            wrapped_q <= step.wrapped;
          end
        end
        S_RESP: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_idx_q    <= res_idx_ext[cba_pkg::IDXW-1:0];
            out_off_q    <= res_idx_ext << shamt;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/cba_checker.sv */
// port-level checker of the allocator, bound to the top level
// depends on cba_pkg and contiguous_block_allocator_macros.svh
`default_nettype none

`include "contiguous_block_allocator_macros.svh"

module cba_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic [cba_pkg::STW-1:0]  out_status_i,
  input wire logic [cba_pkg::IDXW-1:0] out_index_i,
  input wire logic [cba_pkg::OFFW-1:0] out_offset_i
);

  logic                                                   out_stall;
  logic                                                   out_fail;
  logic                                                   out_zero;
  logic [cba_pkg::STW+cba_pkg::IDXW+cba_pkg::OFFW-1:0]    out_payload;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign out_fail    = out_valid_i && (out_status_i != cba_pkg::ST_OK);
  assign out_zero    = (out_index_i == '0) && (out_offset_i == '0);
  assign out_payload = {out_status_i, out_index_i, out_offset_i};

  // a stalled result stays offered
  `CBA_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i, "result dropped while stalled")

  // a stalled result keeps its fields
  `CBA_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_payload), "result changed while stalled")

  // one item at a time: busy right after an accept
  `CBA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i, "ready after accept")

  // a failed request reports no index and no offset
  `CBA_ASSERT_IMPL(a_fail_zero, out_fail, out_zero, "failed result carries index")

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_status_i (out_if.status),
  .out_index_i  (out_if.block_index),
  .out_offset_i (out_if.byte_offset)
);

`default_nettype wire
